// ===== rtl/lcd_mode_line_timer_assert.svh =====
// Assertion macros for the LCD mode and line timer.
// Needs clk_i and rst_ni in the scope of the including module.
`ifndef LCD_MODE_LINE_TIMER_ASSERT_SVH
`define LCD_MODE_LINE_TIMER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define LMT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define LMT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lmt_pkg.sv =====
// Shared types, constants and helpers for the LCD mode and line timer.
// No dependencies.
package lmt_pkg;

  localparam int unsigned VisibleLinesDef = 144;
  localparam int unsigned TotalLinesDef   = 154;

  localparam logic [9:0] DotsOam    = 10'd80;
  localparam logic [9:0] DotsXfer   = 10'd172;
  localparam logic [9:0] DotsHblank = 10'd204;
  localparam logic [9:0] DotsVline  = 10'd456;

  // Largest quotient of a 10-bit dot count by the shortest mode length
  localparam int unsigned ModMaxQuot = 1023 / 80;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_XFER   = 2'd3
  } lcd_mode_e;

  typedef enum logic [2:0] {
    REG_LCD_ENABLE  = 3'd0,
    REG_COMPARE     = 3'd1,
    REG_HBLANK_IRQ  = 3'd2,
    REG_VBLANK_IRQ  = 3'd3,
    REG_OAM_IRQ     = 3'd4,
    REG_COIN_IRQ    = 3'd5
  } cfg_reg_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;

  // Remainder of x by a constant length: parallel compares against the
  // multiples, the highest one that fits wins.
  function automatic logic [9:0] mod_dots(input logic [9:0] x, input logic [9:0] len);
    logic [13:0] r;
    logic [13:0] lim;
    r = 14'(x);
    for (int unsigned k = 1; k <= ModMaxQuot; k++) begin
      lim = 14'(k) * 14'(len);
      if (14'(x) >= lim) begin
        r = 14'(x) - lim;
      end
    end
    return r[9:0];
  endfunction

endpackage

// ===== rtl/lmt_if.sv =====
// Channel interfaces of the LCD mode and line timer: tick in, status out.
// Depends on nothing.
interface lmt_tick_if;
  logic       valid;
  logic       ready;
  logic [3:0] tick_cycles;

  modport source (output valid, output tick_cycles, input ready);
  modport sink   (input valid, input tick_cycles, output ready);
endinterface

interface lmt_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] lcd_mode;
  logic [7:0] line_number;
  logic       coincidence;
  logic       stat_irq;
  logic       vblank_irq;
  logic       draw_request;
  logic       frame_done;

  modport source (output valid, output lcd_mode, output line_number, output coincidence,
                  output stat_irq, output vblank_irq, output draw_request,
                  output frame_done, input ready);
  modport sink   (input valid, input lcd_mode, input line_number, input coincidence,
                  input stat_irq, input vblank_irq, input draw_request,
                  input frame_done, output ready);
endinterface

// ===== rtl/lcd_mode_line_timer.sv =====
// LCD mode and line timer: dot counter, mode sequence, line counter, irqs.
// Depends on lmt_pkg, lmt_if.sv and lcd_mode_line_timer_assert.svh.
//
//  port      | dir | transaction
//  ----------+-----+---------------------------------------------
//  tick_i    | in  | one tick of tick_cycles machine cycles
//  result_o  | out | mode, line and event flags after that tick
//  cfg_*_i   | in  | register write, taken on cfg_we_i
//
// One tick per clock unless stalled; a tick is registered, then its result.
// The input register and the result register both hold their transaction
// under stall, so a tick is taken while a result waits to be collected.
// Reset clears the timing state to sprite search, line 0, dot 0.
// The combinational loop is dot add, remainder by the mode length and line step.

`include "lcd_mode_line_timer_assert.svh"

module lcd_mode_line_timer #(
  parameter int unsigned VISIBLE_LINES = lmt_pkg::VisibleLinesDef,
  parameter int unsigned TOTAL_LINES   = lmt_pkg::TotalLinesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  lmt_tick_if.sink                     tick_i,
  lmt_result_if.source                 result_o,
  input  logic                         cfg_we_i,
  input  logic [lmt_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [lmt_pkg::CfgDataW-1:0] cfg_data_i
);
  import lmt_pkg::*;

  localparam logic [7:0] VisLine   = 8'(VISIBLE_LINES);
  localparam logic [7:0] TotalLine = 8'(TOTAL_LINES);

  // Configuration
  logic       lcd_en_q, hbl_irq_en_q, vbl_irq_en_q, oam_irq_en_q, coin_irq_en_q;
  logic [7:0] cmp_line_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcd_en_q      <= 1'b1;
      cmp_line_q    <= '0;
      hbl_irq_en_q  <= 1'b0;
      vbl_irq_en_q  <= 1'b0;
      oam_irq_en_q  <= 1'b0;
      coin_irq_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_LCD_ENABLE: lcd_en_q      <= cfg_data_i[0];
        REG_COMPARE:    cmp_line_q    <= cfg_data_i;
        REG_HBLANK_IRQ: hbl_irq_en_q  <= cfg_data_i[0];
        REG_VBLANK_IRQ: vbl_irq_en_q  <= cfg_data_i[0];
        REG_OAM_IRQ:    oam_irq_en_q  <= cfg_data_i[0];
        REG_COIN_IRQ:   coin_irq_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Handshake and pipeline control
  logic       in_valid_q, in_valid_d;
  logic [3:0] tick_q;
  logic       res_valid_q, res_valid_d;
  logic       advance, fire, take;

  assign advance      = !res_valid_q || result_o.ready;
  assign fire         = in_valid_q && advance;
  assign tick_i.ready = !in_valid_q || advance;
  assign take         = tick_i.valid && tick_i.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    res_valid_d = advance ? in_valid_q : res_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      tick_q <= tick_i.tick_cycles;
    end
  end

  // Timing state
  logic [9:0] dot_q, dot_d, dot_sum;
  lcd_mode_e  mode_q, mode_d;
  logic [7:0] line_q, line_d, line_inc;
  logic       stat_d, vbl_d, draw_d, frame_d, coin_d;

  assign dot_sum  = dot_q + {4'd0, tick_q, 2'b00};
  assign line_inc = line_q + 8'd1;

  always_comb begin
    dot_d   = dot_q;
    mode_d  = mode_q;
    line_d  = line_q;
    stat_d  = 1'b0;
    vbl_d   = 1'b0;
    draw_d  = 1'b0;
    frame_d = 1'b0;
    if (lcd_en_q) begin
      dot_d = dot_sum;
      case (mode_q)
        MODE_OAM: begin
          if (dot_sum >= DotsOam) begin
            dot_d  = mod_dots(dot_sum, DotsOam);
            mode_d = MODE_XFER;
          end
        end
        MODE_XFER: begin
          if (dot_sum >= DotsXfer) begin
            dot_d  = mod_dots(dot_sum, DotsXfer);
            mode_d = MODE_HBLANK;
            stat_d = hbl_irq_en_q;
          end
        end
        MODE_HBLANK: begin
          if (dot_sum >= DotsHblank) begin
            dot_d  = mod_dots(dot_sum, DotsHblank);
            line_d = line_inc;
            draw_d = 1'b1;
            if (line_inc == VisLine) begin
              mode_d = MODE_VBLANK;
              stat_d = vbl_irq_en_q;
              vbl_d  = 1'b1;
            end else begin
              mode_d = MODE_OAM;
              stat_d = oam_irq_en_q;
            end
          end
        end
        MODE_VBLANK: begin
          if (dot_sum >= DotsVline) begin
            dot_d  = '0;
            line_d = line_inc;
            // line wraps past the frame end; a wrap through 255 stays in vblank
            if (line_inc >= TotalLine) begin
              line_d  = '0;
              mode_d  = MODE_OAM;
              stat_d  = oam_irq_en_q;
              frame_d = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
    coin_d = (line_d == cmp_line_q);
    if (lcd_en_q && coin_d && coin_irq_en_q) begin
      stat_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q  <= '0;
      mode_q <= MODE_OAM;
      line_q <= '0;
    end else if (fire) begin
      dot_q  <= dot_d;
      mode_q <= mode_d;
      line_q <= line_d;
    end
  end

  // Result register
  logic [1:0] r_mode_q;
  logic [7:0] r_line_q;
  logic       r_coin_q, r_stat_q, r_vbl_q, r_draw_q, r_frame_q;

  always_ff @(posedge clk_i) begin
    if (fire) begin
      r_mode_q  <= mode_d;
      r_line_q  <= line_d;
      r_coin_q  <= coin_d;
      r_stat_q  <= stat_d;
      r_vbl_q   <= vbl_d;
      r_draw_q  <= draw_d;
      r_frame_q <= frame_d;
    end
  end

  assign result_o.valid        = res_valid_q;
  assign result_o.lcd_mode     = r_mode_q;
  assign result_o.line_number  = r_line_q;
  assign result_o.coincidence  = r_coin_q;
  assign result_o.stat_irq     = r_stat_q;
  assign result_o.vblank_irq   = r_vbl_q;
  assign result_o.draw_request = r_draw_q;
  assign result_o.frame_done   = r_frame_q;

  // Checks
  `LMT_ASSERT_IMP(a_draw_mode, res_valid_q && r_draw_q,
    r_mode_q == MODE_OAM || r_mode_q == MODE_VBLANK, "draw request outside a line end")
  `LMT_ASSERT_IMP(a_vbl_entry, res_valid_q && r_vbl_q,
    r_draw_q && r_mode_q == MODE_VBLANK && r_line_q == VisLine, "bad vblank entry")
  `LMT_ASSERT_IMP(a_frame_wrap, res_valid_q && r_frame_q,
    r_mode_q == MODE_OAM && r_line_q == 8'd0, "frame end without wrap to line 0")
  `LMT_ASSERT_NXT(a_in_hold, in_valid_q && !advance,
    in_valid_q && $stable(tick_q) && $stable(mode_q), "stalled tick lost or state moved")

endmodule

// ===== tb/tb_lcd_mode_line_timer.sv =====
// Self-checking testbench for lcd_mode_line_timer: directed table, then random phases.
// Needs lmt_pkg, lmt_if.sv and the timer RTL; expected status comes from a local model.
`timescale 1ns / 100ps

module tb_lcd_mode_line_timer;
  import lmt_pkg::*;

  localparam int unsigned VisLines   = 144;
  localparam int unsigned TotLines   = 154;
  localparam int unsigned LenOam     = 80;
  localparam int unsigned LenXfer    = 172;
  localparam int unsigned LenHblank  = 204;
  localparam int unsigned LenVline   = 456;
  localparam int unsigned SettleCyc  = 4;
  localparam int unsigned MaxReports = 10;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  typedef enum logic {
    ROW_TICK,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    lcd_mode_e  mode;
    logic [7:0] line;
    logic       coin;
    logic       stat;
    logic       vbl;
    logic       draw;
    logic       frame;
  } line_status_t;

  typedef struct {
    row_kind_e    kind;
    cfg_reg_e     reg_idx;
    logic [7:0]   data;
    bit           chk;
    line_status_t want;
  } stim_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                cfg_we    = 1'b0;
  cfg_reg_e            cfg_index = REG_LCD_ENABLE;
  logic [CfgDataW-1:0] cfg_data  = '0;

  lmt_tick_if   tick_if ();
  lmt_result_if res_if ();

  lcd_mode_line_timer #(
    .VISIBLE_LINES(VisLines),
    .TOTAL_LINES  (TotLines)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tick_i     (tick_if.sink),
    .result_o   (res_if.source),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always #6 clk_i = ~clk_i;

  // Shadow registers and timing state of the model
  bit         sh_enable  = 1'b1;
  logic [7:0] sh_compare = 8'd0;
  bit         sh_hb_ie   = 1'b0;
  bit         sh_vb_ie   = 1'b0;
  bit         sh_oam_ie  = 1'b0;
  bit         sh_coin_ie = 1'b0;

  logic [9:0] tm_dots = 10'd0;
  lcd_mode_e  tm_mode = MODE_OAM;
  logic [7:0] tm_line = 8'd0;

  int unsigned mismatches  = 0;

  line_status_t line_status_q[$];

  // Driven with each tick: a typed-in expectation overrides the model's
  bit           typed_chk  = 1'b0;
  line_status_t typed_want = '0;

  idle_mode_e  idle_mode = IDLE_NONE;
  int unsigned hold_len  = 0;
  bit          hold_go   = 1'b0;

  function automatic line_status_t advance_timer(input logic [3:0] cyc);
    line_status_t r;
    r = '0;
    if (sh_enable) begin
      tm_dots = tm_dots + {4'd0, cyc, 2'b00};
      case (tm_mode)
        MODE_OAM: begin
          if (tm_dots >= LenOam) begin
            tm_dots = 10'(tm_dots % LenOam);
            tm_mode = MODE_XFER;
          end
        end
        MODE_XFER: begin
          if (tm_dots >= LenXfer) begin
            tm_dots = 10'(tm_dots % LenXfer);
            tm_mode = MODE_HBLANK;
            r.stat  = sh_hb_ie;
          end
        end
        MODE_HBLANK: begin
          if (tm_dots >= LenHblank) begin
            tm_dots = 10'(tm_dots % LenHblank);
            tm_line = tm_line + 8'd1;
            r.draw  = 1'b1;
            if (tm_line == VisLines) begin
              tm_mode = MODE_VBLANK;
              r.stat  = sh_vb_ie;
              r.vbl   = 1'b1;
            end else begin
              tm_mode = MODE_OAM;
              r.stat  = sh_oam_ie;
            end
          end
        end
        default: begin
          // a vblank line restarts the dot count from zero
          if (tm_dots >= LenVline) begin
            tm_dots = 10'd0;
            tm_line = tm_line + 8'd1;
            if (tm_line >= TotLines) begin
              tm_line = 8'd0;
              tm_mode = MODE_OAM;
              r.stat  = sh_oam_ie;
              r.frame = 1'b1;
            end
          end
        end
      endcase
      if (tm_line == sh_compare && sh_coin_ie) r.stat = 1'b1;
    end
    r.coin = (tm_line == sh_compare);
    r.mode = tm_mode;
    r.line = tm_line;
    return r;
  endfunction

  // Monitor: predict on each tick transaction, check each status transaction,
  // and drive the receiver's ready.
  always @(posedge clk_i) begin : monitor
    line_status_t pred;
    line_status_t got;
    line_status_t want;
    bit           hold_seen;
    int unsigned  hold_left;
    int unsigned  stall_pct;
    if (rst_ni) begin
      if (tick_if.valid && tick_if.ready) begin
        pred = advance_timer(tick_if.tick_cycles);
        line_status_q.push_back(typed_chk ? typed_want : pred);
      end
      if (res_if.valid && res_if.ready) begin
        got = '{lcd_mode_e'(res_if.lcd_mode), res_if.line_number, res_if.coincidence,
                res_if.stat_irq, res_if.vblank_irq, res_if.draw_request, res_if.frame_done};
        if (line_status_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("%0t: status transaction with nothing expected", $time);
        end else begin
          want = line_status_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= MaxReports)
              $display("%0t: mismatch exp mode %0d line %0d coin %b stat %b vbl %b draw %b",
                       $time, want.mode, want.line, want.coin, want.stat, want.vbl,
                       want.draw, " frame %b / got mode %0d line %0d coin %b stat %b",
                       want.frame, got.mode, got.line, got.coin, got.stat,
                       " vbl %b draw %b frame %b", got.vbl, got.draw, got.frame);
          end
        end
      end
      if (hold_go != hold_seen) begin
        hold_seen = hold_go;
        hold_left = hold_len;
      end
      stall_pct = (idle_mode == IDLE_RECV) ? 55 : (idle_mode == IDLE_BOTH) ? 33 : 0;
      if (hold_left != 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end else begin
      res_if.ready <= 1'b0;
    end
  end

  task automatic send_tick(input logic [3:0] cyc, input bit chk, input line_status_t want);
    int unsigned idle_pct;
    idle_pct = (idle_mode == IDLE_SEND) ? 55 : (idle_mode == IDLE_BOTH) ? 33 : 0;
    while ($urandom_range(99) < idle_pct) begin
      tick_if.valid       <= 1'b0;
      tick_if.tick_cycles <= 4'($urandom());
      @(posedge clk_i);
    end
    tick_if.valid       <= 1'b1;
    tick_if.tick_cycles <= cyc;
    typed_chk           <= chk;
    typed_want          <= want;
    @(posedge clk_i);
    while (!tick_if.ready) @(posedge clk_i);
  endtask

  // Stop offering ticks and wait until every expected status has come back
  task automatic await_results();
    tick_if.valid <= 1'b0;
    @(posedge clk_i);
    while (line_status_q.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic cfg_write(input cfg_reg_e idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      REG_LCD_ENABLE: sh_enable  = val[0];
      REG_COMPARE:    sh_compare = val;
      REG_HBLANK_IRQ: sh_hb_ie   = val[0];
      REG_VBLANK_IRQ: sh_vb_ie   = val[0];
      REG_OAM_IRQ:    sh_oam_ie  = val[0];
      REG_COIN_IRQ:   sh_coin_ie = val[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  initial begin : limit
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    stim_row_t   rows[24];
    int unsigned phase;
    int unsigned rand_items;
    int unsigned n_items;
    logic [7:0]  cmp;
    bit          lcd_on;
    logic [3:0]  cyc;

    tick_if.valid       = 1'b0;
    tick_if.tick_cycles = 4'd0;

    rows = '{
      '{ROW_TICK, REG_LCD_ENABLE, 8'd0,   1'b1, '{MODE_OAM,    8'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{ROW_TICK, REG_LCD_ENABLE, 8'd15,  1'b1, '{MODE_OAM,    8'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{ROW_TICK, REG_LCD_ENABLE, 8'd15,  1'b1, '{MODE_XFER,   8'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{ROW_CFG,  REG_HBLANK_IRQ, 8'd1,   1'b0, '0},
      '{ROW_TICK, REG_LCD_ENABLE, 8'd15,  1'b0, '0},
      '{ROW_TICK, REG_LCD_ENABLE, 8'd15,  1'b0, '0},
      '{ROW_TICK, REG_LCD_ENABLE, 8'd15,  1'b1, '{MODE_HBLANK, 8'd0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0}},
      '{ROW_CFG,  REG_OAM_IRQ,    8'd1,   1'b0, '0},
      '{ROW_TICK, REG_LCD_ENABLE, 8'd15,  1'b0, '0},
      '{ROW_TICK, REG_LCD_ENABLE, 8'd15,  1'b0, '0},
      '{ROW_TICK, REG_LCD_ENABLE, 8'd15,  1'b1, '{MODE_OAM,    8'd1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0}},
      // LCD off: state frozen, event flags low, coincidence still compared
      '{ROW_CFG,  REG_LCD_ENABLE, 8'd0,   1'b0, '0},
      '{ROW_TICK, REG_LCD_ENABLE, 8'd15,  1'b1, '{MODE_OAM,    8'd1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{ROW_CFG,  REG_COMPARE,    8'd1,   1'b0, '0},
      '{ROW_TICK, REG_LCD_ENABLE, 8'd8,   1'b1, '{MODE_OAM,    8'd1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{ROW_CFG,  REG_COIN_IRQ,   8'd1,   1'b0, '0},
      '{ROW_TICK, REG_LCD_ENABLE, 8'd0,   1'b1, '{MODE_OAM,    8'd1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{ROW_CFG,  REG_LCD_ENABLE, 8'd1,   1'b0, '0},
      // zero tick while enabled: coincidence interrupt still fires
      '{ROW_TICK, REG_LCD_ENABLE, 8'd0,   1'b1, '{MODE_OAM,    8'd1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0}},
      '{ROW_CFG,  REG_COMPARE,    8'd255, 1'b0, '0},
      '{ROW_TICK, REG_LCD_ENABLE, 8'd15,  1'b0, '0},
      '{ROW_CFG,  REG_VBLANK_IRQ, 8'd1,   1'b0, '0},
      '{ROW_TICK, REG_LCD_ENABLE, 8'd5,   1'b0, '0},
      '{ROW_TICK, REG_LCD_ENABLE, 8'd10,  1'b0, '0}
    };

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        await_results();
        cfg_write(rows[i].reg_idx, rows[i].data);
      end else begin
        send_tick(rows[i].data[3:0], rows[i].chk, rows[i].want);
      end
    end
    await_results();

    // Random phases; ticks are mostly the longest so that vblank and the frame end come round
    phase      = 0;
    rand_items = 0;
    while (rand_items < 1400) begin
      lcd_on = (phase % 6) != 5;
      case (phase % 5)
        0:       cmp = 8'd0;
        1:       cmp = 8'd255;
        2:       cmp = 8'(VisLines);
        3:       cmp = 8'(TotLines - 1);
        default: cmp = 8'($urandom_range(TotLines - 1));
      endcase
      cfg_write(REG_LCD_ENABLE, {7'd0, lcd_on});
      cfg_write(REG_COMPARE, cmp);
      cfg_write(REG_HBLANK_IRQ, (phase == 0) ? 8'd1 : (phase == 1) ? 8'd0 : 8'($urandom_range(1)));
      cfg_write(REG_VBLANK_IRQ, (phase == 0) ? 8'd1 : (phase == 1) ? 8'd0 : 8'($urandom_range(1)));
      cfg_write(REG_OAM_IRQ,    (phase == 0) ? 8'd1 : (phase == 1) ? 8'd0 : 8'($urandom_range(1)));
      cfg_write(REG_COIN_IRQ,   (phase == 0) ? 8'd1 : (phase == 1) ? 8'd0 : 8'($urandom_range(1)));
      idle_mode <= idle_mode_e'(phase % 4);
      // long receiver hold-off while ticks keep coming, to back the block up
      if (phase == 2) begin
        hold_len <= 300;
        hold_go  <= ~hold_go;
      end
      n_items = lcd_on ? 140 : 12;
      for (int unsigned i = 0; i < n_items; i++) begin
        if (phase == 3 && i == 70) await_results();
        cyc = ($urandom_range(9) < 9) ? 4'd15 : 4'($urandom_range(15));
        send_tick(cyc, 1'b0, '0);
      end
      rand_items += n_items;
      await_results();
      phase++;
    end

    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && line_status_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
